/* hdl/tmt_pkg.sv */
// Shared types, codes and helpers for the timer table.
// No dependencies; used by tmt_cell, tmt_head and software_timer_table_top.
`timescale 1ns / 1ps
package tmt_pkg;

	localparam int unsigned CountW = 7;

	typedef enum logic [2:0] {
		CMD_ADD       = 3'd0,
		CMD_CANCEL    = 3'd1,
		CMD_TICK      = 3'd2,
		CMD_REBASE    = 3'd3,
		CMD_REMOVE    = 3'd4,
		CMD_COUNT_ALL = 3'd5,
		CMD_COUNT_OWN = 3'd6,
		CMD_CLEAR     = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		KIND_ADDED     = 3'd0,
		KIND_CANCELLED = 3'd1,
		KIND_FIRED     = 3'd2,
		KIND_REBASED   = 3'd3,
		KIND_REMOVED   = 3'd4,
		KIND_COUNT     = 3'd5
	} kind_t;

	typedef struct packed {
		logic        live;
		logic        due;
		logic [15:0] id;
		logic [7:0]  owner;
		logic [31:0] deadline;
		logic [31:0] period;
		logic        persist;
	} slot_t;

	// Command context presented to the head processing unit.
	typedef struct packed {
		cmd_t        cmd;
		logic [31:0] now;
		logic [31:0] delay;
		logic [31:0] reload;
		logic        keep;
		logic [7:0]  owner;
		logic [15:0] tid;
		logic [15:0] id_ctr;
		logic [31:0] prev_now;
		logic        first;
		logic        fire_here;
		logic        placed;
		logic        hit;
	} head_ctx_t;

	typedef struct packed {
		logic place;
		logic hit;
		logic counted;
		logic due_hit;
	} head_flags_t;

	function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? 32'hFFFF_FFFF : s[31:0];
	endfunction

endpackage

/* hdl/tmt_cell.sv */
// One slot cell of the rotating timer chain.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
module tmt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           shift,
	input  tmt_pkg::slot_t slot_in,
	output tmt_pkg::slot_t slot_q
);

	// The whole slot resets to an empty, zeroed entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= slot_in;
		end
	end

endmodule

/* hdl/tmt_head.sv */
// Head unit of the chain: updates one slot per cycle for the command while a pass runs.
// Depends on tmt_pkg.
`timescale 1ns / 1ps
module tmt_head (
	input  tmt_pkg::slot_t      slot_in,
	input  tmt_pkg::head_ctx_t  ctx,
	output tmt_pkg::slot_t      slot_out,
	output tmt_pkg::head_flags_t flags
);

	logic [31:0] left;
	logic        base_due;

	always_comb begin
		slot_out = slot_in;
		flags    = '0;
		left     = (slot_in.deadline > ctx.prev_now) ? (slot_in.deadline - ctx.prev_now) : 32'd0;
		base_due = ctx.first ? (slot_in.live && (slot_in.deadline <= ctx.now)) : slot_in.due;
		unique case (ctx.cmd)
			tmt_pkg::CMD_ADD: begin
				if (!slot_in.live && !ctx.placed) begin
					slot_out.live     = 1'b1;
					slot_out.id       = ctx.id_ctr;
					slot_out.owner    = ctx.owner;
					slot_out.deadline = tmt_pkg::sat_add(ctx.now, ctx.delay);
					slot_out.period   = ctx.reload;
					slot_out.persist  = ctx.keep;
					flags.place       = 1'b1;
				end
			end
			tmt_pkg::CMD_CANCEL: begin
				if (slot_in.live && slot_in.id == ctx.tid && !ctx.hit) begin
					slot_out.live = 1'b0;
					flags.hit     = 1'b1;
				end
			end
			tmt_pkg::CMD_TICK: begin
				if (ctx.fire_here) begin
					if (slot_in.period != 32'd0) begin
						slot_out.deadline = tmt_pkg::sat_add(ctx.now, slot_in.period);
					end else begin
						slot_out.live = 1'b0;
					end
				end
				slot_out.due  = base_due && !ctx.fire_here;
				flags.due_hit = base_due && !ctx.fire_here;
			end
			tmt_pkg::CMD_REBASE: begin
				if (slot_in.live) begin
					if (!slot_in.persist) begin
						slot_out.live = 1'b0;
					end else begin
						slot_out.deadline = tmt_pkg::sat_add(ctx.now, left);
					end
				end
			end
			tmt_pkg::CMD_REMOVE: begin
				if (slot_in.live && slot_in.owner == ctx.owner) begin
					slot_out.live = 1'b0;
					flags.counted = 1'b1;
				end
			end
			tmt_pkg::CMD_COUNT_ALL: begin
				flags.counted = slot_in.live;
			end
			tmt_pkg::CMD_COUNT_OWN: begin
				flags.counted = slot_in.live && slot_in.owner == ctx.owner;
			end
			tmt_pkg::CMD_CLEAR: begin
				flags.counted = slot_in.live;
				slot_out.live = 1'b0;
			end
			default: begin
				slot_out = slot_in;
			end
		endcase
	end

endmodule

/* hdl/software_timer_table_top.sv */
// Timer table top level: a ring of NUM_SLOTS slot cells rotating past one head unit.
// Each command but a tick takes one pass over all NUM_SLOTS slots.
// A tick takes one pass per due slot plus one more, and emits one fired item per pass but the first.
// Asynchronous active-low reset empties the table, sets the id counter to one
// and the remembered clock to zero. Depends on tmt_pkg, tmt_cell and tmt_head.
`timescale 1ns / 1ps
module software_timer_table_top #(
	parameter int unsigned NUM_SLOTS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic [31:0] now,
	input  logic [31:0] delay,
	input  logic [31:0] reload,
	input  logic        keep_on_rebase,
	input  logic [7:0]  owner,
	input  logic [15:0] target_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  kind,
	output logic [15:0] timer_id,
	output logic [7:0]  fired_owner,
	output logic        ok,
	output logic [6:0]  count,
	output logic        last
);

	localparam int unsigned IdxW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_SLOTS - 1);

	typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_RUN} state_t;

	state_t state_q;

	// Latched command item.
	tmt_pkg::cmd_t cmd_q;
	logic [31:0] now_q, delay_q, reload_q;
	logic        keep_q;
	logic [7:0]  owner_q;
	logic [15:0] tid_q;

	// Table-wide state.
	logic [15:0] id_ctr_q;
	logic [31:0] prev_now_q;

	// Pass bookkeeping.
	logic [IdxW-1:0] pos_q;
	logic            first_q;
	logic            placed_q, hit_q;
	logic [tmt_pkg::CountW-1:0] n_q;
	logic            best_v_q;
	logic [15:0]     best_id_q;
	logic [7:0]      best_own_q;
	logic [IdxW-1:0] best_idx_q;
	logic            fire_v_q;
	logic [IdxW-1:0] fire_idx_q;
	logic            pend_v_q;
	logic [15:0]     pend_id_q;
	logic [7:0]      pend_own_q;

	// The chain: cell 0 is the head, each cell takes its upper neighbor,
	// and the top cell takes the slot the head unit just processed.
	tmt_pkg::slot_t cell_q [NUM_SLOTS];
	tmt_pkg::slot_t head_new;
	tmt_pkg::head_ctx_t ctx;
	tmt_pkg::head_flags_t flags;
	logic shift;

	assign shift = (state_q == ST_RUN);

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		tmt_pkg::slot_t nxt;
		if (g == NUM_SLOTS - 1) begin : g_top
			assign nxt = head_new;
		end else begin : g_mid
			assign nxt = cell_q[g+1];
		end
		tmt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.slot_in(nxt),
			.slot_q (cell_q[g])
		);
	end

	always_comb begin
		ctx.cmd       = cmd_q;
		ctx.now       = now_q;
		ctx.delay     = delay_q;
		ctx.reload    = reload_q;
		ctx.keep      = keep_q;
		ctx.owner     = owner_q;
		ctx.tid       = tid_q;
		ctx.id_ctr    = id_ctr_q;
		ctx.prev_now  = prev_now_q;
		ctx.first     = first_q;
		ctx.fire_here = fire_v_q && (pos_q == fire_idx_q);
		ctx.placed    = placed_q;
		ctx.hit       = hit_q;
	end

	tmt_head u_head (
		.slot_in (cell_q[0]),
		.ctx     (ctx),
		.slot_out(head_new),
		.flags   (flags)
	);

	// Values including the slot at the head this cycle.
	logic placed_n, hit_n, cand, best_v_n;
	logic [tmt_pkg::CountW-1:0] n_n;
	logic [15:0] best_id_n;
	logic [7:0]  best_own_n;
	logic [IdxW-1:0] best_idx_n;

	always_comb begin
		placed_n = placed_q | flags.place;
		hit_n    = hit_q | flags.hit;
		n_n      = n_q + tmt_pkg::CountW'(flags.counted);
		// Strict compare keeps the lowest slot index among equal ids.
		cand     = flags.due_hit && (!best_v_q || (cell_q[0].id < best_id_q));
		best_v_n   = best_v_q | cand;
		best_id_n  = cand ? cell_q[0].id : best_id_q;
		best_own_n = cand ? cell_q[0].owner : best_own_q;
		best_idx_n = cand ? pos_q : best_idx_q;
	end

	logic out_take, pass_end;
	assign out_take = out_valid && !out_stall;
	assign pass_end = (state_q == ST_RUN) && (pos_q == LastIdx);
	assign in_stall = (state_q != ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			id_ctr_q   <= 16'd1;
			prev_now_q <= 32'd0;
			out_valid  <= 1'b0;
			pos_q      <= '0;
			first_q    <= 1'b0;
			best_v_q   <= 1'b0;
			fire_v_q   <= 1'b0;
			pend_v_q   <= 1'b0;
			placed_q   <= 1'b0;
			hit_q      <= 1'b0;
			n_q        <= '0;
		end else begin
			if (out_take && !pass_end) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WAIT;
						first_q <= 1'b1;
					end
				end
				ST_WAIT: begin
					// A pass may write the output register at its end, so it starts empty.
					if (!out_valid || out_take) begin
						state_q  <= ST_RUN;
						pos_q    <= '0;
						best_v_q <= 1'b0;
						placed_q <= 1'b0;
						hit_q    <= 1'b0;
						n_q      <= '0;
					end
				end
				ST_RUN: begin
					pos_q    <= pass_end ? '0 : pos_q + IdxW'(1);
					placed_q <= placed_n;
					hit_q    <= hit_n;
					n_q      <= n_n;
					best_v_q <= best_v_n;
					if (cand) begin
						best_id_q  <= best_id_n;
						best_own_q <= best_own_n;
						best_idx_q <= best_idx_n;
					end
					if (pass_end) begin
						first_q <= 1'b0;
						// A tick that found another due slot runs one more pass.
						state_q <= (cmd_q == tmt_pkg::CMD_TICK && best_v_n) ? ST_WAIT : ST_IDLE;
						unique case (cmd_q)
							tmt_pkg::CMD_ADD: begin
								out_valid   <= 1'b1;
								kind        <= tmt_pkg::KIND_ADDED;
								timer_id    <= placed_n ? id_ctr_q : 16'd0;
								fired_owner <= 8'd0;
								ok          <= placed_n;
								count       <= '0;
								last        <= 1'b1;
								if (placed_n) begin
									id_ctr_q <= id_ctr_q + 16'd1;
								end
							end
							tmt_pkg::CMD_CANCEL: begin
								out_valid   <= 1'b1;
								kind        <= tmt_pkg::KIND_CANCELLED;
								timer_id    <= tid_q;
								fired_owner <= 8'd0;
								ok          <= hit_n;
								count       <= '0;
								last        <= 1'b1;
							end
							tmt_pkg::CMD_TICK: begin
								prev_now_q <= now_q;
								// The item found one pass earlier goes out now; whether
								// it is the last is known only once this pass is done.
								if (pend_v_q) begin
									out_valid   <= 1'b1;
									kind        <= tmt_pkg::KIND_FIRED;
									timer_id    <= pend_id_q;
									fired_owner <= pend_own_q;
									ok          <= 1'b1;
									count       <= '0;
									last        <= !best_v_n;
								end
								if (best_v_n) begin
									pend_v_q   <= 1'b1;
									pend_id_q  <= best_id_n;
									pend_own_q <= best_own_n;
									fire_v_q   <= 1'b1;
									fire_idx_q <= best_idx_n;
								end else begin
									pend_v_q <= 1'b0;
									fire_v_q <= 1'b0;
								end
							end
							tmt_pkg::CMD_REBASE: begin
								prev_now_q  <= now_q;
								out_valid   <= 1'b1;
								kind        <= tmt_pkg::KIND_REBASED;
								timer_id    <= 16'd0;
								fired_owner <= 8'd0;
								ok          <= 1'b1;
								count       <= '0;
								last        <= 1'b1;
							end
							tmt_pkg::CMD_REMOVE, tmt_pkg::CMD_CLEAR: begin
								if (cmd_q == tmt_pkg::CMD_CLEAR) begin
									id_ctr_q   <= 16'd1;
									prev_now_q <= 32'd0;
								end
								out_valid   <= 1'b1;
								kind        <= tmt_pkg::KIND_REMOVED;
								timer_id    <= 16'd0;
								fired_owner <= 8'd0;
								ok          <= 1'b1;
								count       <= n_n;
								last        <= 1'b1;
							end
							tmt_pkg::CMD_COUNT_ALL, tmt_pkg::CMD_COUNT_OWN: begin
								out_valid   <= 1'b1;
								kind        <= tmt_pkg::KIND_COUNT;
								timer_id    <= 16'd0;
								fired_owner <= 8'd0;
								ok          <= 1'b1;
								count       <= n_n;
								last        <= 1'b1;
							end
						endcase
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command item capture.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			cmd_q    <= tmt_pkg::cmd_t'(command);
			now_q    <= now;
			delay_q  <= delay;
			reload_q <= reload;
			keep_q   <= keep_on_rebase;
			owner_q  <= owner;
			tid_q    <= target_id;
		end
	end

endmodule
